// File: rtl/lrlbc_pkg.sv
// ----------------------------------------------------------------------------
// lrlbc_pkg
// shared widths, the front-to-back request type and a run length helper
// ----------------------------------------------------------------------------
package lrlbc_pkg;

    localparam int RUN_COUNT_BITS = 15;
    localparam int COPY_CNT_W     = $clog2(RUN_COUNT_BITS);
    localparam int BYTE_W         = 8;
    localparam int VERB_W         = 9;
    localparam int SIDE_VALUE_W   = 14;
    localparam int SIDE_WIDTH_W   = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int M_TDATA_W      = 32;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SIDE = 1'b1;

    // one request per input item that makes results
    typedef struct packed {
        logic                      lead_en;   // byte goes out before the side result
        logic                      flush_en;  // copies plus side result
        logic                      tail_en;   // byte goes out after the flush
        logic [BYTE_W-1:0]         data_byte;
        logic [BYTE_W-1:0]         run_byte;
        logic [RUN_COUNT_BITS-1:0] run_len;
        logic                      col_last;
    } cmd_t;

    // floor(log2 len), zero for len below two
    function automatic logic [COPY_CNT_W-1:0] floor_log2(
        input logic [RUN_COUNT_BITS-1:0] len
    );
        logic [COPY_CNT_W-1:0] k;
        k = '0;
        for (int i = 1; i < RUN_COUNT_BITS; i++) begin
            if (len[i]) begin
                k = COPY_CNT_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/log_run_length_byte_coder_unit.sv
// ----------------------------------------------------------------------------
// log_run_length_byte_coder_unit
// run length byte coder with log2 copy count and side-bit results
// ----------------------------------------------------------------------------
// input stream: one column byte per request in s_tdata, s_tlast on the
// column's final byte. output stream: one result per request, m_tuser gives
// the kind (byte or side-bit group), m_tlast marks the column's final result.
// cfg_wen/cfg_wdata load extra_verbatim; write it only while the coder is idle.
// a result passes through the request queue and the output register to m_tvalid.
// throughput: one byte per cycle while each byte makes at most one result and
// m_tready stays high; a byte that closes a run of length L adds floor(log2 L)
// copies plus a side result, absorbed run bytes add none.
// the output register is the limit: one result leaves per cycle while m_tready is high.
// a four-entry request queue lets input keep flowing while the output
// expands a run or m_tready is low; s_tready drops only when it fills.
// reset clears the coder state, the queue, m_tvalid and extra_verbatim.
// at each column end all coder state except extra_verbatim returns to reset.
// ----------------------------------------------------------------------------
module log_run_length_byte_coder_unit import lrlbc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [BYTE_W-1:0]    cfg_wdata,    // extra_verbatim
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,      // [7:0] data_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // [7:0] out_byte, [21:8] side_value,
                                               // [25:22] side_width, [26] end_of_item
    output logic                 m_tuser,      // [0] kind
    output logic                 m_tlast
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    lrlbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    lrlbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    lrlbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // no request lost to a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_push && q_full))
        else $error("request pushed into full queue");

    // side results always carry a nonzero width
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SIDE |-> m_tdata[25:22] != '0)
        else $error("side result with zero width");

    // byte results leave the side fields clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_BYTE |-> m_tdata[25:8] == '0)
        else $error("byte result with side fields set");

    // column end only on an item's final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[26])
        else $error("column end without item end");

endmodule

// File: rtl/lrlbc_front.sv
// ----------------------------------------------------------------------------
// lrlbc_front
// takes column bytes, tracks pair / verbatim / run state, issues requests
// ----------------------------------------------------------------------------
module lrlbc_front import lrlbc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_VERB   = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;

    phase_t                    phase_reg, phase_next;
    logic [BYTE_W-1:0]         ev_reg, ev_next;
    logic [BYTE_W-1:0]         prev_reg, prev_next;
    logic [VERB_W-1:0]         vleft_reg, vleft_next;
    logic [VERB_W-1:0]         vleft_dec;
    logic [RUN_COUNT_BITS-1:0] count_reg, count_next;
    logic [RUN_COUNT_BITS-1:0] count_inc;
    logic                      accept;
    logic                      same;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign same      = (s_tdata == prev_reg);
    assign count_inc = (count_reg == RUN_MAX) ? count_reg : count_reg + 1'b1;
    assign vleft_dec = vleft_reg - 1'b1;

    always_comb begin
        phase_next = phase_reg;
        ev_next    = cfg_wen ? cfg_wdata : ev_reg;
        prev_next  = prev_reg;
        vleft_next = vleft_reg;
        count_next = count_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        q_cmd.data_byte = s_tdata;
        q_cmd.run_byte  = prev_reg;
        q_cmd.col_last  = s_tlast;
        if (accept) begin
            unique case (phase_reg)
                PH_RUN: begin
                    if (same) begin
                        count_next = count_inc;
                        if (s_tlast) begin
                            q_push         = 1'b1;
                            q_cmd.flush_en = 1'b1;
                            q_cmd.run_len  = count_inc;
                        end
                    end else begin
                        // run closed by a new byte: flush, then the byte
                        q_push         = 1'b1;
                        q_cmd.flush_en = 1'b1;
                        q_cmd.tail_en  = 1'b1;
                        q_cmd.run_len  = count_reg;
                        prev_next      = s_tdata;
                        phase_next     = PH_NORMAL;
                        count_next     = '0;
                    end
                end
                PH_VERB: begin
                    q_push = 1'b1;
                    if (!same) begin
                        q_cmd.tail_en = 1'b1;
                        prev_next     = s_tdata;
                        phase_next    = PH_NORMAL;
                    end else begin
                        vleft_next = vleft_dec;
                        if (vleft_dec == '0) begin
                            phase_next = PH_RUN;
                            count_next = '0;
                        end
                        // column ends right as verbatim copy completes: empty run
                        if (vleft_dec == '0 && s_tlast) begin
                            q_cmd.lead_en  = 1'b1;
                            q_cmd.flush_en = 1'b1;
                        end else begin
                            q_cmd.tail_en = 1'b1;
                        end
                    end
                end
                default: begin
                    q_push        = 1'b1;
                    q_cmd.tail_en = 1'b1;
                    if (same) begin
                        phase_next = PH_VERB;
                        vleft_next = VERB_W'(ev_reg) + 1'b1;
                    end else begin
                        phase_next = PH_NORMAL;
                    end
                    prev_next = s_tdata;
                end
            endcase
            if (s_tlast) begin
                phase_next = PH_NORMAL;
                prev_next  = '0;
                vleft_next = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            ev_reg    <= '0;
            prev_reg  <= '0;
            vleft_reg <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            ev_reg    <= ev_next;
            prev_reg  <= prev_next;
            vleft_reg <= vleft_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/lrlbc_queue.sv
// ----------------------------------------------------------------------------
// lrlbc_queue
// small request queue between front and back
// ----------------------------------------------------------------------------
module lrlbc_queue import lrlbc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/lrlbc_back.sv
// ----------------------------------------------------------------------------
// lrlbc_back
// expands one request into bytes, run copies and the side result
// ----------------------------------------------------------------------------
module lrlbc_back import lrlbc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  cmd_t                    q_head,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    typedef enum logic [1:0] {
        BK_LEAD = 2'd0,
        BK_COPY = 2'd1,
        BK_SIDE = 2'd2,
        BK_TAIL = 2'd3
    } bk_t;

    bk_t                       step_reg, step_next;
    bk_t                       eff;
    logic [COPY_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COPY_CNT_W-1:0]     k;
    logic [RUN_COUNT_BITS-1:0] len_mask;
    logic [SIDE_VALUE_W-1:0]   side_value;
    logic [SIDE_WIDTH_W-1:0]   side_width;
    logic                      load;
    logic                      emit;
    logic                      cmd_last;

    logic                      valid_reg;
    logic                      kind_reg, kind_next;
    logic [BYTE_W-1:0]         byte_reg, byte_next;
    logic [SIDE_VALUE_W-1:0]   sv_reg, sv_next;
    logic [SIDE_WIDTH_W-1:0]   sw_reg, sw_next;
    logic                      eoi_reg;
    logic                      eoc_reg;

    assign k        = floor_log2(q_head.run_len);
    assign len_mask = (RUN_COUNT_BITS'(1) << k) - RUN_COUNT_BITS'(1);

    always_comb begin
        if (k == '0) begin
            side_value = SIDE_VALUE_W'(q_head.run_len[0]);
            side_width = SIDE_WIDTH_W'(1);
        end else begin
            side_value = SIDE_VALUE_W'(q_head.run_len & len_mask);
            side_width = SIDE_WIDTH_W'(k);
        end
    end

    // skip steps the request does not use
    always_comb begin
        if (step_reg == BK_LEAD && q_head.lead_en) begin
            eff = BK_LEAD;
        end else if ((step_reg == BK_LEAD || step_reg == BK_COPY) && q_head.flush_en
                     && k != '0) begin
            eff = BK_COPY;
        end else if (step_reg != BK_TAIL && q_head.flush_en) begin
            eff = BK_SIDE;
        end else begin
            eff = BK_TAIL;
        end
    end

    assign load = !valid_reg || m_tready;
    assign emit = !q_empty && load;

    always_comb begin
        step_next = step_reg;
        cnt_next  = cnt_reg;
        kind_next = KIND_BYTE;
        byte_next = q_head.data_byte;
        sv_next   = '0;
        sw_next   = '0;
        cmd_last  = 1'b0;
        unique case (eff)
            BK_LEAD: begin
                cmd_last  = !q_head.flush_en && !q_head.tail_en;
                step_next = BK_COPY;
            end
            BK_COPY: begin
                byte_next = q_head.run_byte;
                if (cnt_reg == k - 1'b1) begin
                    step_next = BK_SIDE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_SIDE: begin
                kind_next = KIND_SIDE;
                byte_next = '0;
                sv_next   = side_value;
                sw_next   = side_width;
                cmd_last  = !q_head.tail_en;
                step_next = BK_TAIL;
            end
            BK_TAIL: begin
                cmd_last = 1'b1;
            end
        endcase
        if (cmd_last) begin
            step_next = BK_LEAD;
            cnt_next  = '0;
        end
    end

    assign q_pop = emit && cmd_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= BK_LEAD;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                step_reg <= step_next;
                cnt_reg  <= cnt_next;
            end
            if (load) begin
                valid_reg <= !q_empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            sv_reg   <= sv_next;
            sw_reg   <= sw_next;
            eoi_reg  <= cmd_last;
            eoc_reg  <= cmd_last && q_head.col_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = eoc_reg;
    assign m_tdata  = M_TDATA_W'({eoi_reg, sw_reg, sv_reg, byte_reg});

endmodule

// File: dv/log_run_length_byte_coder_unit_tb.sv
// ----------------------------------------------------------------------------
// log_run_length_byte_coder_unit_tb
// self-checking bench for the log run length byte coder: a directed table
// of run shapes, a long absorbed run, then random columns under several
// extra_verbatim settings. each result is scored against a behavioral
// model of the coder or a typed row, with random stalls on both streams
// ----------------------------------------------------------------------------
module log_run_length_byte_coder_unit_tb;
    import lrlbc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int QUIET_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 300;
    localparam int LONG_RUN_BYTES = 30;
    localparam int PHASE_QUOTA    = 70;
    localparam int NUM_PHASES     = 5;
    localparam int TIMEOUT_CYCLES = 2000000;
    localparam int PRINT_CAP      = 40;
    localparam int DIR_ROWS       = 25;

    typedef enum logic [1:0] {
        CPH_NORMAL   = 2'd0,
        CPH_VERBATIM = 2'd1,
        CPH_RUN      = 2'd2
    } coder_phase_t;

    typedef struct {
        logic                    kind;
        logic [BYTE_W-1:0]       out_byte;
        logic [SIDE_VALUE_W-1:0] side_value;
        logic [SIDE_WIDTH_W-1:0] side_width;
        logic                    eoi;
        logic                    eoc;
    } coder_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0]       data_byte;
        logic                    last_byte;
        logic                    typed;
        logic                    kind;
        logic [BYTE_W-1:0]       out_byte;
        logic [SIDE_VALUE_W-1:0] side_value;
        logic [SIDE_WIDTH_W-1:0] side_width;
        logic                    eoi;
        logic                    eoc;
    } dir_row_t;

    // typed rows carry their single result, the rest go through the model
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b1, 1'b0}, // pair on reset byte
        '{8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // run closed by new byte
        '{8'hFF, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b1, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // absorbed last byte
        '{8'h00, 1'b1, 1'b1, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b1, 1'b1}, // one byte column
        '{8'h05, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h05, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h05, 1'b1, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // verbatim ends column
        '{8'h09, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h09, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h09, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0B, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // empty run flushed
        '{8'h0B, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // verbatim broken
        '{8'h0C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0C, 1'b0, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0},
        '{8'h0C, 1'b1, 1'b0, KIND_BYTE, 8'h00, 14'd0, 4'd0, 1'b0, 1'b0}, // run flushed at end
        '{8'hFF, 1'b1, 1'b1, KIND_BYTE, 8'hFF, 14'd0, 4'd0, 1'b1, 1'b1}
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] data_byte
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [7:0] out_byte, [21:8] side_value,
                                            // [25:22] side_width, [26] end_of_item
    logic                 m_tuser;          // [0] kind
    logic                 m_tlast;

    // coder model state
    logic [BYTE_W-1:0]         extra_verbatim_m = '0;
    logic [BYTE_W-1:0]         prev_byte        = '0;
    coder_phase_t              cur_phase        = CPH_NORMAL;
    logic [VERB_W-1:0]         verb_left        = '0;
    logic [RUN_COUNT_BITS-1:0] run_len          = '0;

    coder_result_t step_results[$];
    coder_result_t pending_results[$];

    int mismatch_count = 0;
    bit tx_idle_en     = 1'b1;
    bit rx_idle_en     = 1'b1;
    bit hold_rx_req    = 1'b0;

    log_run_length_byte_coder_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("log_run_length_byte_coder_unit verification failed");
        $finish;
    end

    function automatic void add_result(input logic kind, input logic [BYTE_W-1:0] ob,
                                       input logic [SIDE_VALUE_W-1:0] sv,
                                       input logic [SIDE_WIDTH_W-1:0] sw);
        coder_result_t r;
        r.kind       = kind;
        r.out_byte   = ob;
        r.side_value = sv;
        r.side_width = sw;
        r.eoi        = 1'b0;
        r.eoc        = 1'b0;
        step_results = {step_results, r};
    endfunction

    // floor(log2 L) copies of the run byte, then the side-bit group
    function automatic void close_run();
        logic [RUN_COUNT_BITS-1:0] x;
        logic [RUN_COUNT_BITS-1:0] mask;
        int                        k;
        x = run_len >> 1;
        k = 0;
        while (x != '0) begin
            k++;
            x = x >> 1;
        end
        for (int i = 0; i < k; i++) begin
            add_result(KIND_BYTE, prev_byte, '0, '0);
        end
        if (k == 0) begin
            add_result(KIND_SIDE, '0, SIDE_VALUE_W'(run_len[0]), SIDE_WIDTH_W'(1));
        end else begin
            mask = RUN_COUNT_BITS'((1 << k) - 1);
            add_result(KIND_SIDE, '0, SIDE_VALUE_W'(run_len & mask), SIDE_WIDTH_W'(k));
        end
        run_len   = '0;
        cur_phase = CPH_NORMAL;
    endfunction

    // results one input byte causes, left in step_results
    function automatic void code_byte(input logic [BYTE_W-1:0] b, input logic lst);
        coder_result_t r;
        step_results.delete();
        case (cur_phase)
            CPH_RUN: begin
                if (b == prev_byte) begin
                    if (run_len != {RUN_COUNT_BITS{1'b1}}) begin
                        run_len = run_len + 1'b1;
                    end
                    if (lst) begin
                        close_run();
                    end
                end else begin
                    close_run();
                    add_result(KIND_BYTE, b, '0, '0);
                    prev_byte = b;
                end
            end
            CPH_VERBATIM: begin
                add_result(KIND_BYTE, b, '0, '0);
                if (b != prev_byte) begin
                    prev_byte = b;
                    cur_phase = CPH_NORMAL;
                end else begin
                    verb_left = verb_left - 1'b1;
                    if (verb_left == '0) begin
                        cur_phase = CPH_RUN;
                        run_len   = '0;
                        if (lst) begin
                            close_run();
                        end
                    end
                end
            end
            default: begin
                add_result(KIND_BYTE, b, '0, '0);
                if (b == prev_byte) begin
                    cur_phase = CPH_VERBATIM;
                    verb_left = {1'b0, extra_verbatim_m} + 1'b1;
                end else begin
                    cur_phase = CPH_NORMAL;
                end
                prev_byte = b;
            end
        endcase
        if (step_results.size() > 0) begin
            r            = step_results.pop_back();
            r.eoi        = 1'b1;
            r.eoc        = lst;
            step_results = {step_results, r};
        end
        if (lst) begin
            prev_byte = '0;
            cur_phase = CPH_NORMAL;
            verb_left = '0;
            run_len   = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        coder_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_tdata, '0);
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(e.kind));
                if (m_tdata[7:0] !== e.out_byte)
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(e.out_byte));
                if (m_tdata[21:8] !== e.side_value)
                    report_mismatch("side_value", 32'(m_tdata[21:8]), 32'(e.side_value));
                if (m_tdata[25:22] !== e.side_width)
                    report_mismatch("side_width", 32'(m_tdata[25:22]), 32'(e.side_width));
                if (m_tdata[26] !== e.eoi)
                    report_mismatch("end_of_item", 32'(m_tdata[26]), 32'(e.eoi));
                if (m_tdata[31:27] !== 5'd0)
                    report_mismatch("tdata pad", 32'(m_tdata[31:27]), 32'(5'd0));
                if (m_tlast !== e.eoc)
                    report_mismatch("end_of_column", 32'(m_tlast), 32'(e.eoc));
            end
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin : result_sink
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one input request; returns at the edge that takes it
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic lst,
                             input bit use_typed, input coder_result_t typed_res,
                             output int made);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        code_byte(b, lst);
        made = step_results.size();
        if (use_typed) begin
            pending_results = {pending_results, typed_res};
        end else begin
            pending_results = {pending_results, step_results};
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_extra_verbatim(input logic [BYTE_W-1:0] v);
        wait_results_drained();
        // absorbed bytes leave nothing pending but may still be in flight
        repeat (QUIET_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen          <= 1'b0;
        extra_verbatim_m  = v;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return BYTE_W'($urandom_range(0, 3));
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // one column of runs; some runs long enough to reach the absorb phase
    task automatic send_column(input logic [BYTE_W-1:0] ev, output int items_sent);
        coder_result_t dummy;
        logic [BYTE_W-1:0] b;
        int n_runs;
        int len;
        int made;
        bit noise;
        items_sent = 0;
        dummy      = '{default: '0};
        noise      = ($urandom_range(0, 7) == 0);
        n_runs     = noise ? $urandom_range(1, 12) : $urandom_range(1, 4);
        for (int r = 0; r < n_runs; r++) begin
            b = pick_byte();
            if (noise) begin
                len = 1;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 3);
                    6, 7, 8, 9:       len = $urandom_range(4, 20);
                    15:               len = int'(ev) + 2 + $urandom_range(8, 24);
                    default:          len = int'(ev) + 2 + $urandom_range(0, 8);
                endcase
            end
            for (int i = 0; i < len; i++) begin
                send_item(b, (r == n_runs - 1) && (i == len - 1), 1'b0, dummy, made);
                items_sent++;
            end
        end
    endtask

    initial begin : stimulus
        coder_result_t typed_res;
        logic [BYTE_W-1:0] ev;
        int made;
        int produced;
        bit paused;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, extra_verbatim at its reset value
        for (int i = 0; i < DIR_ROWS; i++) begin
            typed_res.kind       = DIR_TABLE[i].kind;
            typed_res.out_byte   = DIR_TABLE[i].out_byte;
            typed_res.side_value = DIR_TABLE[i].side_value;
            typed_res.side_width = DIR_TABLE[i].side_width;
            typed_res.eoi        = DIR_TABLE[i].eoi;
            typed_res.eoc        = DIR_TABLE[i].eoc;
            send_item(DIR_TABLE[i].data_byte, DIR_TABLE[i].last_byte,
                      DIR_TABLE[i].typed, typed_res, made);
        end

        // long absorbed run, closed by a new last byte
        write_extra_verbatim(8'd0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < LONG_RUN_BYTES; i++) begin
            send_item(8'h5A, 1'b0, 1'b0, typed_res, made);
        end
        send_item(8'hA5, 1'b1, 1'b0, typed_res, made);

        paused = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       ev = 8'd3;
                1:       ev = 8'd0;
                2:       ev = 8'd1;
                3:       ev = BYTE_W'($urandom_range(0, 15));
                default: ev = BYTE_W'($urandom_range(4, 20));
            endcase
            write_extra_verbatim(ev);
            tx_idle_en = (ph != NUM_PHASES - 1);
            rx_idle_en = (ph != NUM_PHASES - 1);
            if (ph == 0) begin
                hold_rx_req = 1'b1;
            end
            produced = 0;
            while (produced < PHASE_QUOTA) begin
                send_column(ev, made);
                produced += made;
                if (ph == 2 && !paused && produced >= PHASE_QUOTA / 2) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("log_run_length_byte_coder_unit verification clean");
        end else begin
            $display("log_run_length_byte_coder_unit verification failed");
        end
        $finish;
    end

endmodule
